// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the sharpening filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on aclk, switched off while aresetn is low.
`define LSH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked on aclk, checked during reset as well.
`define LSH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/lsh_pkg.sv =====
// Shared types and constants of the 3x3 Laplacian sharpening filter.
package lsh_pkg;

    localparam int PIX_W        = 8;
    localparam int NUM_CH       = 3;
    localparam int DATA_W       = PIX_W * NUM_CH;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = 2;
    localparam int FIFO_CNT_W   = 3;

    // Kind of an input transaction, carried on s_tuser.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIX_W-1:0] chan_t;

    // Control that travels with an item from the window stage to the merge stage.
    typedef struct packed {
        logic valid;
        logic interior;
        logic frame_end;
    } ctl_t;

endpackage

// ===== hdl/lsh_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lsh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lsh_lane.sv =====
// One channel lane: 5*centre minus the four neighbours, clamped to a byte.
module lsh_lane (
    input  lsh_pkg::chan_t center,
    input  lsh_pkg::chan_t left,
    input  lsh_pkg::chan_t right,
    input  lsh_pkg::chan_t up,
    input  lsh_pkg::chan_t down,
    output lsh_pkg::chan_t sharp
);

    // Range is -1020 .. 1275, so 12 signed bits are enough.
    logic        [10:0] five_c;
    logic signed [11:0] acc;

    always_comb begin
        five_c = {1'b0, center, 2'b00} + {3'b000, center};
        acc    = $signed({1'b0, five_c})
               - $signed({4'b0000, left})
               - $signed({4'b0000, right})
               - $signed({4'b0000, up})
               - $signed({4'b0000, down});
        if (acc < 12'sd0) begin
            sharp = '0;
        end else if (acc > 12'sd255) begin
            sharp = '1;
        end else begin
            sharp = acc[lsh_pkg::PIX_W-1:0];
        end
    end

endmodule

// ===== hdl/lsh_merge.sv =====
// Merge stage: joins the lane results, zeroes border pixels and queues results.
module lsh_merge (
    input  logic                            clk,
    input  logic                            rstn,
    input  lsh_pkg::ctl_t                   ctl,
    input  logic [lsh_pkg::DATA_W-1:0]      lane_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsh_pkg::DATA_W-1:0]      m_tdata,
    output logic                            m_tlast,
    output logic [lsh_pkg::FIFO_CNT_W-1:0]  level
);

    typedef struct packed {
        logic                       last;
        logic [lsh_pkg::DATA_W-1:0] data;
    } entry_t;

    entry_t                         queue_mem [lsh_pkg::FIFO_DEPTH];
    entry_t                         push_entry;
    logic [lsh_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lsh_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lsh_pkg::FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           push, pop;

    always_comb begin
        push            = ctl.valid;
        pop             = m_tvalid && m_tready;
        push_entry.last = ctl.frame_end;
        push_entry.data = ctl.interior ? lane_data : '0;
        wr_ptr_next     = push ? wr_ptr_reg + lsh_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next     = pop ? rd_ptr_reg + lsh_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next        = cnt_reg + lsh_pkg::FIFO_CNT_W'(push)
                        - lsh_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = queue_mem[rd_ptr_reg].data;
    assign m_tlast  = queue_mem[rd_ptr_reg].last;
    assign level    = cnt_reg;

endmodule

// ===== hdl/laplacian_sharpen_3x3_stream.sv =====
// Top level of the 3x3 Laplacian sharpening filter for RGB pixel streams.
// Throughput: one transaction per clock while s_tready is high; the line buffer port pair is read every cycle.
// A result reaches m_tvalid through the window stage registers and the merge queue,
// and results trail the pixel stream by one row plus one pixel.
// Reset (aresetn low, synchronous) clears counters, queue and registers to 640 x 480;
// the line buffers are not cleared since every result uses only rows of the current frame.
module laplacian_sharpen_3x3_stream #(
    parameter int MAX_WIDTH = lsh_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsh_pkg::DATA_W-1:0]       s_tdata,   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
    input  logic                             s_tuser,   // mode: 0 pixel, 1 flush tick
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsh_pkg::DATA_W-1:0]       m_tdata,   // sharp_a [7:0], sharp_b [15:8], sharp_c [23:16]
    output logic                             m_tlast,   // frame_end
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsh_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lsh_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lsh_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // Column index width, and a width that holds any effective row length.
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = (CW + 1 > lsh_pkg::WIDTH_REG_W) ? CW + 1 : lsh_pkg::WIDTH_REG_W;
    localparam int RW = lsh_pkg::HEIGHT_REG_W;
    localparam int TW = LW + RW;
    localparam int PW = lsh_pkg::PIX_W;

    // Configuration registers. A write also restarts the frame position.
    logic [lsh_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [lsh_pkg::HEIGHT_REG_W-1:0] height_reg;
    lsh_pkg::reg_idx_t                cfg_idx;
    logic                             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = lsh_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lsh_pkg::WIDTH_REG_W'(lsh_pkg::RESET_WIDTH);
            height_reg <= lsh_pkg::HEIGHT_REG_W'(lsh_pkg::RESET_HEIGHT);
        end else if (cfg_wr) begin
            case (cfg_idx)
                lsh_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[lsh_pkg::WIDTH_REG_W-1:0];
                lsh_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[lsh_pkg::HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lsh_pkg::REG_IMAGE_WIDTH:  prdata = lsh_pkg::CFG_DATA_W'(width_reg);
            lsh_pkg::REG_IMAGE_HEIGHT: prdata = lsh_pkg::CFG_DATA_W'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    // Effective frame size: register values clamped to the supported range.
    logic [LW-1:0] w_raw, w_eff;
    logic [RW-1:0] h_eff;
    logic [TW-1:0] total_reg;

    always_comb begin
        w_raw = LW'(width_reg);
        if (w_raw < LW'(lsh_pkg::MIN_DIM)) begin
            w_eff = LW'(lsh_pkg::MIN_DIM);
        end else if (w_raw > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (height_reg < RW'(lsh_pkg::MIN_DIM)) begin
            h_eff = RW'(lsh_pkg::MIN_DIM);
        end else if (height_reg > RW'(lsh_pkg::MAX_HEIGHT)) begin
            h_eff = RW'(lsh_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // Results per frame. Registered; it settles long before the first flush tick.
    always_ff @(posedge aclk) begin
        total_reg <= TW'(w_eff) * TW'(h_eff);
    end

    // Frame position, result count and the flag that says all pixels are in.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [TW-1:0] out_cnt_reg, out_cnt_next;
    logic          frame_in_reg, frame_in_next;

    logic          in_fire, is_flush, pix_take, flush_take;
    logic [CW:0]   col_inc;
    logic          col_wrap;
    logic [RW-1:0] row_inc;
    logic          emit, interior, frame_end;
    logic [TW-1:0] out_cnt_inc;

    // Window stage registers: control plus the accepted pixel and its column.
    lsh_pkg::ctl_t           ctl_b_reg, ctl_b_next;
    logic                    pix_b_reg;
    logic [CW-1:0]           col_b_reg;
    logic [lsh_pkg::DATA_W-1:0] px_b_reg;

    logic [lsh_pkg::FIFO_CNT_W-1:0] level;
    logic [lsh_pkg::FIFO_CNT_W-1:0] credit_used;

    // Accept while the queue has room for everything already on its way.
    assign credit_used = level + lsh_pkg::FIFO_CNT_W'(ctl_b_reg.valid);
    assign s_tready    = credit_used < lsh_pkg::FIFO_CNT_W'(lsh_pkg::FIFO_DEPTH);

    always_comb begin
        in_fire     = s_tvalid && s_tready;
        is_flush    = (s_tuser == lsh_pkg::MODE_FLUSH);
        // Pixels arriving after the frame is complete and flush ticks arriving
        // before it is complete are dropped without a result.
        pix_take    = in_fire && !is_flush && !frame_in_reg;
        flush_take  = in_fire && is_flush && frame_in_reg;

        col_inc     = {1'b0, col_reg} + (CW + 1)'(1);
        col_wrap    = LW'(col_inc) >= w_eff;
        row_inc     = row_reg + RW'(1);

        // The first row plus one pixel of a frame produces no result.
        emit        = (row_reg > RW'(1)) || ((row_reg == RW'(1)) && (col_reg != '0));
        // The centre lies one row up and one column left of the new pixel.
        interior    = (row_reg > RW'(1)) && (col_reg > CW'(1));

        out_cnt_inc = out_cnt_reg + TW'(1);
        frame_end   = flush_take && (out_cnt_inc >= total_reg);

        col_next      = col_reg;
        row_next      = row_reg;
        out_cnt_next  = out_cnt_reg;
        frame_in_next = frame_in_reg;

        if (cfg_wr || frame_end) begin
            col_next      = '0;
            row_next      = '0;
            out_cnt_next  = '0;
            frame_in_next = 1'b0;
        end else if (pix_take) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_inc;
                if (row_inc >= h_eff) begin
                    frame_in_next = 1'b1;
                end
            end else begin
                col_next = col_inc[CW-1:0];
            end
            if (emit) begin
                out_cnt_next = out_cnt_inc;
            end
        end else if (flush_take) begin
            out_cnt_next = out_cnt_inc;
        end

        ctl_b_next.valid     = (pix_take && emit) || flush_take;
        ctl_b_next.interior  = pix_take && interior;
        ctl_b_next.frame_end = frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            out_cnt_reg  <= '0;
            frame_in_reg <= 1'b0;
            ctl_b_reg    <= '0;
            pix_b_reg    <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            out_cnt_reg  <= out_cnt_next;
            frame_in_reg <= frame_in_next;
            ctl_b_reg    <= ctl_b_next;
            pix_b_reg    <= pix_take;
        end
    end

    always_ff @(posedge aclk) begin
        col_b_reg <= col_reg;
        px_b_reg  <= s_tdata;
    end

    // Line buffers. Both are read at the current column every cycle, so the
    // data for an accepted pixel is ready in the window stage in the next cycle,
    // where the pixel and the row above are written back at the same column.
    logic [lsh_pkg::DATA_W-1:0] above_rd, two_above_rd;

    lsh_ram #(
        .WIDTH (lsh_pkg::DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .clk     (aclk),
        .wr_en   (pix_b_reg),
        .wr_addr (col_b_reg),
        .wr_data (px_b_reg),
        .rd_addr (col_reg),
        .rd_data (above_rd)
    );

    lsh_ram #(
        .WIDTH (lsh_pkg::DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .clk     (aclk),
        .wr_en   (pix_b_reg),
        .wr_addr (col_b_reg),
        .wr_data (above_rd),
        .rd_addr (col_reg),
        .rd_data (two_above_rd)
    );

    // Window registers. Only the taps that the cross-shaped kernel uses are
    // kept: the top centre, the middle left and centre, and the bottom centre,
    // all as they stood before the current pixel shifts in.
    logic [lsh_pkg::DATA_W-1:0] top_c_reg, mid_l_reg, mid_c_reg, bot_c_reg;

    always_ff @(posedge aclk) begin
        if (pix_b_reg) begin
            top_c_reg <= two_above_rd;
            mid_l_reg <= mid_c_reg;
            mid_c_reg <= above_rd;
            bot_c_reg <= px_b_reg;
        end
    end

    // One lane per colour channel; the right neighbour comes straight from
    // the row-above buffer.
    logic [lsh_pkg::DATA_W-1:0] lane_data;

    for (genvar ch = 0; ch < lsh_pkg::NUM_CH; ch++) begin : g_lane
        lsh_lane u_lane (
            .center (mid_c_reg[ch*PW +: PW]),
            .left   (mid_l_reg[ch*PW +: PW]),
            .right  (above_rd[ch*PW +: PW]),
            .up     (top_c_reg[ch*PW +: PW]),
            .down   (bot_c_reg[ch*PW +: PW]),
            .sharp  (lane_data[ch*PW +: PW])
        );
    end

    // Merge stage: border results become zero and every result is queued.
    lsh_merge u_merge (
        .clk       (aclk),
        .rstn      (aresetn),
        .ctl       (ctl_b_reg),
        .lane_data (lane_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .level     (level)
    );

endmodule

// ===== hdl/lsh_checker.sv =====
// Port-level checker for the sharpening filter, bound to its top level.
`include "assert_macros.svh"

module lsh_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lsh_pkg::DATA_W-1:0]       m_tdata,
    input logic                             m_tlast,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [lsh_pkg::CFG_ADDR_W-1:0]   paddr,
    input logic [lsh_pkg::CFG_DATA_W-1:0]   pwdata,
    input logic [lsh_pkg::CFG_DATA_W-1:0]   prdata
);

    property p_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
    endproperty

    property p_width_readback;
        (psel && penable && pwrite && !paddr[2]) ##1 (!paddr[2] && !(psel && penable && pwrite))
        |-> (prdata[11:0] == $past(pwdata[11:0])) && (prdata[31:12] == '0);
    endproperty

    // A stalled result keeps its value.
    `LSH_ASSERT(a_hold, p_hold, "result changed while stalled")

    // Reset empties the result queue.
    `LSH_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result pending after reset")

    // The frame's last result is a border pixel and therefore zero.
    `LSH_ASSERT(a_last_zero, m_tvalid && m_tlast |-> m_tdata == '0, "frame end result not zero")

    // A width write reads back on the following cycle.
    `LSH_ASSERT(a_width_readback, p_width_readback, "width register readback mismatch")

endmodule

bind laplacian_sharpen_3x3_stream lsh_checker u_lsh_checker (.*);
